// ===== rtl/core/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Types and constants for the frequency-ordered key/value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES = 64;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [6:0] CAP_RESET = 7'd64;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [30:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_EVICT,
    ST_UNLINK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LINK,
    ST_LINK2,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/lfu_cache_replacement.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_replacement
// Key/value cache with least-frequently-used eviction and least-recently-used
// tie break; entries live in memories, order kept as a doubly linked list.
// ----------------------------------------------------------------------------
//  channel | signals                     | direction
//  req     | req_valid req_stall req     | in  (func key value)
//  rsp     | rsp_valid rsp_stall rsp     | out (hit read_value), gets only
//  cfg     | cfg_we cfg_wdata            | in  capacity_in_use
//
// one beat at a time: a key search over ENTRIES slots (one read of the key
// memory each), then a tail-to-head walk of the order list (at most one
// step per entry held) and the link states ST_LINK and ST_LINK2; a get's
// result then waits while rsp_stall is high. the slot memories share one
// read port.
// reset clears valid bits, list pointers and count at once; no clearing pass.
// req_stall stays high while a beat is in work or its result waits.
module lfu_cache_replacement (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lfu_pkg::req_t     req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lfu_pkg::rsp_t     rsp,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata
);
  import lfu_pkg::*;

  // slot memories: key, data, uses, next, prev
  logic [30:0]   mem_key  [ENTRIES];
  logic [31:0]   mem_data [ENTRIES];
  logic [31:0]   mem_uses [ENTRIES];
  logic [IW-1:0] mem_next [ENTRIES];
  logic [IW-1:0] mem_prev [ENTRIES];

  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]      head, tail;
  logic [CW-1:0]      count;
  logic [6:0]         cap_reg;

  state_t state, state_next;
  req_t   cur;
  logic [IW-1:0] scan, slot, walk, free_slot;
  logic          found, walk_found;
  logic [31:0]   bump_uses;

  // one shared read port
  logic [IW-1:0] rd_addr;
  logic [30:0]   rd_key;
  logic [31:0]   rd_data, rd_uses;
  logic [IW-1:0] rd_next, rd_prev;

  always_ff @(posedge clk) begin
    rd_key  <= mem_key[rd_addr];
    rd_data <= mem_data[rd_addr];
    rd_uses <= mem_uses[rd_addr];
    rd_next <= mem_next[rd_addr];
    rd_prev <= mem_prev[rd_addr];
  end

  // saturating bump of the count just read
  assign bump_uses = (rd_uses == '1) ? rd_uses : rd_uses + 32'd1;

  // write ports: one per memory, driven by the sequencer
  logic          wk_en, wd_en, wu_en, wn_en, wp_en;
  logic [IW-1:0] wk_a, wd_a, wu_a, wn_a, wp_a;
  logic [30:0]   wk_d;
  logic [31:0]   wd_d, wu_d;
  logic [IW-1:0] wn_d, wp_d;

  always_ff @(posedge clk) begin
    if (wk_en) mem_key[wk_a]  <= wk_d;
    if (wd_en) mem_data[wd_a] <= wd_d;
    if (wu_en) mem_uses[wu_a] <= wu_d;
    if (wn_en) mem_next[wn_a] <= wn_d;
    if (wp_en) mem_prev[wp_a] <= wp_d;
  end

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) free_slot = IW'(i);
    end
  end

  logic [CW-1:0] cap_eff;
  always_comb begin
    if (cap_reg == 7'd0) cap_eff = CW'(1);
    else if ({25'd0, cap_reg} > ENTRIES) cap_eff = CW'(ENTRIES);
    else cap_eff = CW'(cap_reg);
  end

  // the link step needs the walk target's next
  logic [IW-1:0] j_next;
  logic [31:0]   link_uses;
  logic          is_head, is_tail;

  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    rd_addr = scan;
    wk_en = 1'b0; wd_en = 1'b0; wu_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
    wk_a = slot; wd_a = slot; wu_a = slot; wn_a = slot; wp_a = slot;
    wk_d = cur.key; wd_d = cur.value; wu_d = link_uses; wn_d = '0; wp_d = '0;
    case (state)
      ST_IDLE:     if (req_valid) state_next = ST_SCAN;
      ST_SCAN:     begin
        rd_addr = scan;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (valid[scan] && rd_key == cur.key) state_next = ST_UNLINK;
        else if (scan == IW'(ENTRIES - 1)) begin
          if (cur.func == FUNC_GET) state_next = ST_OUT;
          else if (count >= cap_eff && count != '0) state_next = ST_EVICT;
          else state_next = ST_WALK_RD;
        end else state_next = ST_SCAN;
      end
      ST_EVICT:    begin
        rd_addr = head;
        state_next = ST_UNLINK;
      end
      ST_UNLINK:   begin
        // rd_* holds the slot being removed
        if (!is_head) begin wn_en = 1'b1; wn_a = rd_prev; wn_d = rd_next; end
        if (!is_tail) begin wp_en = 1'b1; wp_a = rd_next; wp_d = rd_prev; end
        if (found && cur.func == FUNC_PUT) begin wd_en = 1'b1; wd_a = slot; end
        if (found) begin wu_en = 1'b1; wu_a = slot; wu_d = bump_uses; end
        else begin
          wk_en = 1'b1; wk_a = free_slot; wd_en = 1'b1; wd_a = free_slot;
          wu_en = 1'b1; wu_a = free_slot; wu_d = 32'd1;
        end
        state_next = ST_WALK_RD;
      end
      ST_WALK_RD:  begin
        rd_addr = walk;
        // new key lands in its slot while the walk runs
        if (!found) begin
          wk_en = 1'b1; wd_en = 1'b1; wu_en = 1'b1; wu_d = 32'd1;
        end
        if (count == '0) state_next = ST_LINK;
        else state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (rd_uses <= link_uses || walk == head) state_next = ST_LINK;
        else state_next = ST_WALK_RD;
      end
      ST_LINK:     begin
        rd_addr = walk;
        if (count == '0) state_next = ST_LINK2;
        else if (walk_found) begin
          wp_en = 1'b1; wp_a = slot; wp_d = walk;
          wn_en = 1'b1; wn_a = walk; wn_d = slot;
          state_next = ST_LINK2;
        end else begin
          wn_en = 1'b1; wn_a = slot; wn_d = head;
          wp_en = 1'b1; wp_a = head; wp_d = slot;
          state_next = ST_LINK2;
        end
      end
      ST_LINK2:    begin
        // tail already moved to the slot when it went behind the old tail
        if (count != '0 && walk_found && tail != slot) begin
          wn_en = 1'b1; wn_a = slot; wn_d = j_next;
          wp_en = 1'b1; wp_a = j_next; wp_d = slot;
        end
        state_next = (cur.func == FUNC_GET) ? ST_OUT : ST_IDLE;
      end
      ST_OUT:      if (!rsp_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0; head <= '0; tail <= '0; count <= '0; cap_reg <= CAP_RESET;
    end else begin
      if (cfg_we) cap_reg <= cfg_wdata;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur <= req; scan <= '0; found <= 1'b0;
            rsp <= '0;
          end
        end
        ST_SCAN_CHK: begin
          if (valid[scan] && rd_key == cur.key) begin
            found <= 1'b1; slot <= scan;
            is_head <= (scan == head); is_tail <= (scan == tail);
          end else scan <= scan + IW'(1);
          if (!(valid[scan] && rd_key == cur.key) && scan == IW'(ENTRIES - 1)
              && cur.func == FUNC_PUT && !(count >= cap_eff && count != '0)) begin
            slot <= free_slot; link_uses <= 32'd1; walk <= tail;
          end
        end
        ST_EVICT: begin
          is_head <= 1'b1; is_tail <= (head == tail);
          valid[head] <= 1'b0;
        end
        ST_UNLINK: begin
          if (is_head) head <= rd_next;
          if (is_tail) tail <= rd_prev;
          count <= count - CW'(1);
          if (found) begin
            link_uses <= bump_uses;
            rsp.hit <= 1'b1; rsp.read_value <= rd_data;
          end else begin
            slot <= free_slot; link_uses <= 32'd1; valid[free_slot] <= 1'b1;
          end
          walk <= is_tail ? rd_prev : tail;
        end
        ST_WALK_RD: begin
          if (!found && valid[slot] == 1'b0) valid[slot] <= 1'b1;
          walk_found <= 1'b0;
        end
        ST_WALK_CHK: begin
          if (rd_uses <= link_uses) walk_found <= 1'b1;
          else if (walk != head) walk <= rd_prev;
        end
        ST_LINK: begin
          count <= count + CW'(1);
          if (count == '0) begin head <= slot; tail <= slot; end
          else if (walk_found) begin if (walk == tail) tail <= slot; end
          else head <= slot;
        end
        default: ;
      endcase
    end
  end

  // next pointer of the walk target, read in the link cycle
  assign j_next = rd_next;
endmodule
